>>> rtl/core/x86d_pkg.sv
// Shared types, codes and helpers for the x86-64 subset decoder.
`timescale 1ns / 1ps

package x86d_pkg;

  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 200;

  localparam logic [4:0] NO_REG = 5'd17;
  localparam logic [4:0] RIP_REG = 5'd16;

  // operand kinds
  localparam logic [2:0] K_NONE = 3'd0;
  localparam logic [2:0] K_REG  = 3'd1;
  localparam logic [2:0] K_IMM  = 3'd2;
  localparam logic [2:0] K_PC   = 3'd3;
  localparam logic [2:0] K_SMEM = 3'd4;
  localparam logic [2:0] K_MEM  = 3'd5;
  localparam logic [2:0] K_DISP = 3'd6;

  // displacement size codes
  localparam logic [1:0] DSZ_NONE = 2'd0;
  localparam logic [1:0] DSZ_8    = 2'd1;
  localparam logic [1:0] DSZ_32   = 2'd2;

  typedef enum logic [4:0] {
    OP_MOV, OP_ADD, OP_OR, OP_AND, OP_SUB, OP_XOR, OP_CMP, OP_TEST, OP_LEA,
    OP_MOVZX, OP_SHL, OP_SHR, OP_PUSH, OP_POP, OP_RET, OP_JZ, OP_JNZ, OP_JA,
    OP_CALL, OP_JMP
  } op_e;

  typedef struct packed {
    logic        ok;
    logic        isreg;
    logic [3:0]  regf;
    logic [3:0]  rmreg;
    logic [2:0]  kind;
    logic [4:0]  idx;
    logic [4:0]  base;
    logic [3:0]  scale;
    logic [1:0]  dsz;
    logic [2:0]  len;
    logic        rip;
    logic [31:0] disp;
    logic [15:0] used;
  } mrm_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  len;
    op_e         op;
    logic [3:0]  attr;
    logic [10:0] opnd0;
    logic [10:0] opnd1;
    logic [63:0] imm;
    logic [31:0] disp;
    logic [4:0]  base;
    logic [3:0]  scale;
    logic [1:0]  dsz;
    logic [15:0] used;
    logic [11:0] fmod;
    logic [11:0] ftst;
    logic [11:0] fund;
    logic [2:0]  flow;
  } dec_t;

  function automatic logic [31:0] sx8to32(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

>>> rtl/core/x86d_modrm.sv
// ModRM / SIB / displacement parser.
`timescale 1ns / 1ps

module x86d_modrm (
  input  logic [47:0]         bytes_i,   // ModRM byte in bits 7:0
  input  logic [3:0]          avail_i,   // valid bytes from the ModRM byte on
  input  logic [2:0]          rex_i,     // REX R, X, B
  output x86d_pkg::mrm_t      mrm_o
);
  import x86d_pkg::*;

  logic [7:0]  b0, b1;
  logic [1:0]  md, ss;
  logic [2:0]  rmf, xf, bf;
  logic [3:0]  xi, bi;
  logic        hx, hb, need32, has_sib;
  logic [2:0]  pos;
  logic [31:0] dbytes;

  always_comb begin
    b0      = bytes_i[7:0];
    b1      = bytes_i[15:8];
    md      = b0[7:6];
    rmf     = b0[2:0];
    ss      = b1[7:6];
    xf      = b1[5:3];
    bf      = b1[2:0];
    xi      = {rex_i[1], xf};
    bi      = {rex_i[0], bf};
    hx      = (xf != 3'd4) || rex_i[1];
    hb      = (md != 2'd0) || (bf != 3'd5);
    has_sib = 1'b0;
    need32  = 1'b0;
    mrm_o       = '0;
    mrm_o.base  = NO_REG;
    mrm_o.regf  = {rex_i[2], b0[5:3]};
    mrm_o.ok    = (avail_i >= 4'd1);
    if (md == 2'd3) begin
      mrm_o.isreg = 1'b1;
      mrm_o.rmreg = {rex_i[0], rmf};
    end else if (rmf == 3'd4) begin
      has_sib = 1'b1;
      if (avail_i < 4'd2) mrm_o.ok = 1'b0;
      need32 = (md == 2'd0) && !hb;
      if (hx) begin
        mrm_o.kind  = K_MEM;
        mrm_o.idx   = {1'b0, xi};
        mrm_o.base  = hb ? {1'b0, bi} : NO_REG;
        mrm_o.scale = (ss == 2'd0) ? 4'd0 : (4'd1 << ss);
        mrm_o.used  = (16'd1 << xi) | (hb ? (16'd1 << bi) : 16'd0);
      end else if (hb) begin
        mrm_o.kind = K_SMEM;
        mrm_o.idx  = {1'b0, bi};
        mrm_o.used = 16'd1 << bi;
      end else begin
        mrm_o.kind = K_DISP;
      end
    end else if (md == 2'd0 && rmf == 3'd5) begin
      mrm_o.kind = K_SMEM;
      mrm_o.idx  = RIP_REG;
      mrm_o.rip  = 1'b1;
      need32     = 1'b1;
    end else begin
      mrm_o.kind = K_SMEM;
      mrm_o.idx  = {1'b0, rex_i[0], rmf};
      mrm_o.used = 16'd1 << {rex_i[0], rmf};
    end

    pos    = has_sib ? 3'd2 : 3'd1;
    dbytes = has_sib ? bytes_i[47:16] : bytes_i[39:8];
    mrm_o.len = pos;
    if (md == 2'd3) begin
      mrm_o.len = 3'd1;
    end else if (md == 2'd1) begin
      if ({1'b0, avail_i} < {2'b0, pos} + 5'd1) mrm_o.ok = 1'b0;
      mrm_o.disp = sx8to32(dbytes[7:0]);
      mrm_o.dsz  = DSZ_8;
      mrm_o.len  = pos + 3'd1;
    end else if (md == 2'd2 || need32) begin
      if ({1'b0, avail_i} < {2'b0, pos} + 5'd4) mrm_o.ok = 1'b0;
      mrm_o.disp = dbytes;
      mrm_o.dsz  = DSZ_32;
      mrm_o.len  = pos + 3'd4;
    end
  end

endmodule

>>> rtl/core/x86d_decode.sv
// Single-pass instruction decode of one byte window.
`timescale 1ns / 1ps

module x86d_decode #(
  parameter int WINDOW_BYTES = 12
) (
  input  logic                long_mode_i,
  input  logic [63:0]         bytes_low_i,
  input  logic [31:0]         bytes_high_i,
  input  logic [3:0]          byte_count_i,
  output x86d_pkg::dec_t      dec_o
);
  import x86d_pkg::*;

  localparam logic [3:0] A_DST    = 4'd1;
  localparam logic [3:0] A_SIGNED = 4'd2;
  localparam logic [3:0] A_RIP    = 4'd4;
  localparam logic [3:0] A_W64    = 4'd8;

  localparam logic [2:0] SZ_NONE = 3'd0;
  localparam logic [2:0] SZ_8    = 3'd1;
  localparam logic [2:0] SZ_16   = 3'd2;
  localparam logic [2:0] SZ_32   = 3'd3;
  localparam logic [2:0] SZ_64   = 3'd4;

  localparam logic [2:0] FLOW_RET  = 3'd1;
  localparam logic [2:0] FLOW_COND = 3'd2;
  localparam logic [2:0] FLOW_CALL = 3'd3;
  localparam logic [2:0] FLOW_JMP  = 3'd4;

  function automatic logic [10:0] opnd_reg(logic [3:0] idx, logic [2:0] sz);
    return {sz, 1'b0, idx, K_REG};
  endfunction

  function automatic logic [10:0] opnd_imm(logic [2:0] sz, logic [2:0] kind);
    return {sz, 5'd0, kind};
  endfunction

  function automatic logic [63:0] sx32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [63:0] sx8(logic [7:0] v);
    return {{56{v[7]}}, v};
  endfunction

  function automatic dec_t put_reg(dec_t di, logic [3:0] idx, logic [2:0] sz, logic slot);
    dec_t o;
    o = di;
    if (slot) o.opnd1 = opnd_reg(idx, sz);
    else o.opnd0 = opnd_reg(idx, sz);
    o.used = o.used | (16'd1 << idx);
    return o;
  endfunction

  function automatic dec_t put_rm(dec_t di, mrm_t m, logic [2:0] sz, logic slot);
    dec_t        o;
    logic [10:0] v;
    o = di;
    if (m.isreg) begin
      v = opnd_reg(m.rmreg, sz);
      o.used = o.used | (16'd1 << m.rmreg);
    end else begin
      v = {sz, (m.kind == K_DISP) ? 5'd0 : m.idx, m.kind};
      o.base  = m.base;
      o.scale = m.scale;
      o.dsz   = m.dsz;
      o.disp  = m.disp;
      o.used  = o.used | m.used;
      if (m.rip) o.attr = o.attr | A_RIP;
    end
    if (slot) o.opnd1 = v;
    else o.opnd0 = v;
    return o;
  endfunction

  // {undefined, tested, modified}
  function automatic logic [35:0] alu_flags(op_e op);
    logic [35:0] f;
    f = '0;
    case (op)
      OP_ADD, OP_SUB, OP_CMP: f = {12'h000, 12'h000, 12'h8d5};
      OP_AND:                 f = {12'h010, 12'h000, 12'h8c5};
      OP_OR:                  f = {12'h000, 12'h010, 12'h0c4};
      OP_XOR, OP_TEST:        f = {12'h010, 12'h000, 12'h0c4};
      default:                f = '0;
    endcase
    return f;
  endfunction

  function automatic op_e alu_kind(logic [7:0] op);
    op_e k;
    case (op)
      8'h01, 8'h03: k = OP_ADD;
      8'h09, 8'h0b: k = OP_OR;
      8'h21, 8'h23: k = OP_AND;
      8'h29, 8'h2b: k = OP_SUB;
      8'h31, 8'h33: k = OP_XOR;
      8'h39, 8'h3b: k = OP_CMP;
      default:      k = OP_TEST;
    endcase
    return k;
  endfunction

  logic [7:0]  w  [16];
  logic [7:0]  rw [16];
  logic [3:0]  avail, a_rel, a1, a2, ipos, n_imm;
  logic        rexp, front_ok, rexbad, ok, is_to_rm, selok;
  logic [7:0]  rex, op;
  logic [2:0]  bsz, sel1;
  logic [31:0] ib;
  logic [35:0] fl;
  op_e         gop;
  mrm_t        m1, m2;
  dec_t        d;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      if (i < 8) w[i] = bytes_low_i[8*i +: 8];
      else if (i < 12) w[i] = bytes_high_i[8*(i-8) +: 8];
      else w[i] = 8'h00;
    end
    avail = (byte_count_i > 4'(WINDOW_BYTES)) ? 4'(WINDOW_BYTES) : byte_count_i;
    rexp  = (w[0][7:4] == 4'h4);
    rex   = rexp ? w[0] : 8'h00;
    for (int i = 0; i < 16; i++) begin
      if (!rexp) rw[i] = w[i];
      else if (i < 15) rw[i] = w[i+1];
      else rw[i] = 8'h00;
    end
    a_rel = avail - {3'b0, rexp};
    a1    = (a_rel >= 4'd1) ? a_rel - 4'd1 : 4'd0;
    a2    = (a_rel >= 4'd2) ? a_rel - 4'd2 : 4'd0;
  end

  x86d_modrm u_mrm1 (
    .bytes_i ({rw[6], rw[5], rw[4], rw[3], rw[2], rw[1]}),
    .avail_i (a1),
    .rex_i   (rex[2:0]),
    .mrm_o   (m1)
  );

  x86d_modrm u_mrm2 (
    .bytes_i ({rw[7], rw[6], rw[5], rw[4], rw[3], rw[2]}),
    .avail_i (a2),
    .rex_i   (rex[2:0]),
    .mrm_o   (m2)
  );

  always_comb begin
    front_ok = long_mode_i && (avail != 4'd0) &&
               !(rexp && ((avail < 4'd2) || (w[1][7:4] == 4'h4)));
    rexbad   = rexp && !rex[3];
    op       = rw[0];
    bsz      = rex[3] ? SZ_64 : SZ_32;
    sel1     = m1.regf[2:0];
    ipos     = 4'd1 + {1'b0, m1.len};
    ib       = {rw[ipos + 4'd3], rw[ipos + 4'd2], rw[ipos + 4'd1], rw[ipos]};
    is_to_rm = 1'b0;
    selok    = 1'b0;
    n_imm    = 4'd0;
    gop      = OP_ADD;
    fl       = '0;
    ok       = 1'b0;
    d        = '0;
    d.base   = NO_REG;
    d.attr   = rex[3] ? A_W64 : 4'd0;

    unique case (op) inside
      8'h89, 8'h8b: begin
        ok = !rexbad && m1.ok;
        d.op = OP_MOV;
        d.attr = d.attr | A_DST;
        if (op == 8'h89) begin
          d = put_rm(d, m1, bsz, 1'b0);
          d = put_reg(d, m1.regf, bsz, 1'b1);
        end else begin
          d = put_reg(d, m1.regf, bsz, 1'b0);
          d = put_rm(d, m1, bsz, 1'b1);
        end
        d.len = 4'd1 + {1'b0, m1.len};
      end
      [8'hb8:8'hbf]: begin
        n_imm = rex[3] ? 4'd8 : 4'd4;
        ok = !rexbad && ({1'b0, n_imm} + 5'd1 <= {1'b0, a_rel});
        d.op = OP_MOV;
        d.attr = d.attr | A_DST;
        d = put_reg(d, {rex[0], op[2:0]}, bsz, 1'b0);
        if (rex[3]) begin
          d.opnd1 = opnd_imm(SZ_64, K_IMM);
          d.imm = {rw[8], rw[7], rw[6], rw[5], rw[4], rw[3], rw[2], rw[1]};
        end else begin
          d.attr = d.attr | A_SIGNED;
          d.opnd1 = opnd_imm(SZ_32, K_IMM);
          d.imm = sx32({rw[4], rw[3], rw[2], rw[1]});
        end
        d.len = 4'd1 + n_imm;
      end
      8'hc7: begin
        ok = !rexbad && m1.ok && (sel1 == 3'd0) && ({1'b0, ipos} + 5'd4 <= {1'b0, a_rel});
        d.op = OP_MOV;
        d.attr = d.attr | A_DST | A_SIGNED;
        d = put_rm(d, m1, bsz, 1'b0);
        d.opnd1 = opnd_imm(SZ_32, K_IMM);
        d.imm = sx32(ib);
        d.len = ipos + 4'd4;
      end
      [8'h50:8'h5f]: begin
        ok = (rex == 8'h00) || (rex == 8'h41);
        d.op = op[3] ? OP_POP : OP_PUSH;
        d.attr = A_W64 | (op[3] ? A_DST : 4'd0);
        d = put_reg(d, {rex[0], op[2:0]}, SZ_64, 1'b0);
        d.len = 4'd1;
      end
      8'h6a, 8'h68: begin
        n_imm = (op == 8'h6a) ? 4'd1 : 4'd4;
        ok = !rexp && ({1'b0, n_imm} + 5'd1 <= {1'b0, a_rel});
        d.op = OP_PUSH;
        d.attr = A_W64 | A_SIGNED;
        if (op == 8'h6a) begin
          d.opnd0 = opnd_imm(SZ_8, K_IMM);
          d.imm = sx8(rw[1]);
        end else begin
          d.opnd0 = opnd_imm(SZ_32, K_IMM);
          d.imm = sx32({rw[4], rw[3], rw[2], rw[1]});
        end
        d.len = 4'd1 + n_imm;
      end
      8'hc3: begin
        ok = !rexp;
        d.op = OP_RET;
        d.attr = A_W64;
        d.flow = FLOW_RET;
        d.len = 4'd1;
      end
      8'hc2: begin
        ok = !rexp && (a_rel >= 4'd3);
        d.op = OP_RET;
        d.attr = A_W64;
        d.flow = FLOW_RET;
        d.opnd0 = opnd_imm(SZ_16, K_IMM);
        d.imm = {48'd0, rw[2], rw[1]};
        d.len = 4'd3;
      end
      8'h74, 8'h75, 8'h77: begin
        ok = !rexp && (a_rel >= 4'd2);
        d.op = (op == 8'h74) ? OP_JZ : (op == 8'h75) ? OP_JNZ : OP_JA;
        d.attr = A_W64;
        d.flow = FLOW_COND;
        d.ftst = (op == 8'h77) ? 12'h041 : 12'h040;
        d.opnd0 = opnd_imm(SZ_8, K_PC);
        d.imm = sx8(rw[1]);
        d.len = 4'd2;
      end
      8'he8, 8'he9: begin
        ok = !rexp && (a_rel >= 4'd5);
        d.op = (op == 8'he8) ? OP_CALL : OP_JMP;
        d.attr = A_W64;
        d.flow = (op == 8'he8) ? FLOW_CALL : FLOW_JMP;
        d.opnd0 = opnd_imm(SZ_32, K_PC);
        d.imm = sx32({rw[4], rw[3], rw[2], rw[1]});
        d.len = 4'd5;
      end
      8'heb: begin
        ok = !rexp && (a_rel >= 4'd2);
        d.op = OP_JMP;
        d.attr = A_W64;
        d.flow = FLOW_JMP;
        d.opnd0 = opnd_imm(SZ_8, K_PC);
        d.imm = sx8(rw[1]);
        d.len = 4'd2;
      end
      8'h01, 8'h09, 8'h21, 8'h29, 8'h31, 8'h39, 8'h85,
      8'h03, 8'h0b, 8'h23, 8'h2b, 8'h33, 8'h3b: begin
        is_to_rm = !op[1];
        gop = alu_kind(op);
        ok = !rexbad && m1.ok;
        d.op = gop;
        if (gop != OP_CMP && gop != OP_TEST) d.attr = d.attr | A_DST;
        if (is_to_rm) begin
          d = put_rm(d, m1, bsz, 1'b0);
          d = put_reg(d, m1.regf, bsz, 1'b1);
        end else begin
          d = put_reg(d, m1.regf, bsz, 1'b0);
          d = put_rm(d, m1, bsz, 1'b1);
        end
        fl = alu_flags(gop);
        {d.fund, d.ftst, d.fmod} = fl;
        d.len = 4'd1 + {1'b0, m1.len};
      end
      8'h81, 8'h83, 8'hf7: begin
        if (op == 8'hf7) begin
          selok = (sel1 == 3'd0);
          gop = OP_TEST;
        end else begin
          selok = 1'b1;
          case (sel1)
            3'd0:    gop = OP_ADD;
            3'd1:    gop = OP_OR;
            3'd4:    gop = OP_AND;
            3'd5:    gop = OP_SUB;
            3'd6:    gop = OP_XOR;
            3'd7:    gop = OP_CMP;
            default: selok = 1'b0;
          endcase
        end
        n_imm = (op == 8'h83) ? 4'd1 : 4'd4;
        ok = !rexbad && m1.ok && selok && ({1'b0, ipos} + {1'b0, n_imm} <= {1'b0, a_rel});
        d.op = gop;
        d.attr = d.attr | A_SIGNED;
        if (gop != OP_CMP && gop != OP_TEST) d.attr = d.attr | A_DST;
        d = put_rm(d, m1, bsz, 1'b0);
        if (op == 8'h83) begin
          d.opnd1 = opnd_imm(SZ_8, K_IMM);
          d.imm = sx8(ib[7:0]);
        end else begin
          d.opnd1 = opnd_imm(SZ_32, K_IMM);
          d.imm = sx32(ib);
        end
        fl = alu_flags(gop);
        {d.fund, d.ftst, d.fmod} = fl;
        d.len = ipos + n_imm;
      end
      8'h8d: begin
        ok = !rexbad && m1.ok && !m1.isreg;
        d.op = OP_LEA;
        d.attr = d.attr | A_DST;
        d = put_reg(d, m1.regf, bsz, 1'b0);
        d = put_rm(d, m1, SZ_NONE, 1'b1);
        d.len = 4'd1 + {1'b0, m1.len};
      end
      8'h0f: begin
        ok = (a_rel >= 4'd2) && ((rw[1] == 8'hb6) || (rw[1] == 8'hb7)) && !rexbad &&
             m2.ok && !((rw[1] == 8'hb6) && m2.isreg && !rexp && m2.rmreg[2]);
        d.op = OP_MOVZX;
        d.attr = d.attr | A_DST;
        d = put_reg(d, m2.regf, bsz, 1'b0);
        d = put_rm(d, m2, (rw[1] == 8'hb6) ? SZ_8 : SZ_16, 1'b1);
        d.len = 4'd2 + {1'b0, m2.len};
      end
      8'hd1, 8'hd3, 8'hc1: begin
        n_imm = (op == 8'hc1) ? 4'd1 : 4'd0;
        selok = (sel1 == 3'd4) || (sel1 == 3'd5);
        ok = !rexbad && m1.ok && selok && ({1'b0, ipos} + {1'b0, n_imm} <= {1'b0, a_rel});
        d.op = (sel1 == 3'd4) ? OP_SHL : OP_SHR;
        d.attr = d.attr | A_DST;
        d = put_rm(d, m1, bsz, 1'b0);
        if (op == 8'hd3) begin
          d = put_reg(d, 4'd1, SZ_8, 1'b1);
        end else begin
          d.opnd1 = opnd_imm(SZ_8, K_IMM);
          d.imm = (op == 8'hc1) ? {56'd0, ib[7:0]} : 64'd1;
        end
        if (op == 8'hd1) begin
          d.fmod = 12'h8c5;
          d.fund = 12'h010;
        end else begin
          d.fmod = 12'h0c5;
          d.fund = 12'h810;
        end
        d.len = ipos + n_imm;
      end
      default: ok = 1'b0;
    endcase

    d.len = d.len + {3'b0, rexp};
    d.hit = 1'b1;
    if (!(ok && front_ok)) d = '0;
    dec_o = d;
  end

endmodule

>>> rtl/core/x86_64_subset_instruction_decoder.sv
// Each input transfer reaches the result through an input register and then a result register.
// Throughput: one instruction window per cycle, set by the single decode pass between
// the two registers; either register stalls only when the downstream side holds off.
// Reset: valid flags clear and long_mode returns to 1; payload registers are not reset.
// Decode is purely combinational between the registers; there is no clearing pass.
`timescale 1ns / 1ps

module x86_64_subset_instruction_decoder #(
  parameter int WINDOW_BYTES = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,      // long_mode
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // bytes_low[63:0], bytes_high[95:64], byte_count[99:96], zero pad
  input  logic [x86d_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // length[3:0], operation[8:4], attributes[12:9], first_operand[23:13],
  // second_operand[34:24], immediate[98:35], displacement[130:99],
  // address_info[141:131], used_registers[157:142], eflags_masks[193:158],
  // flow_class[196:194], zero pad
  output logic [x86d_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  output logic [0:0]                          m_axis_tuser_o    // hit
);
  import x86d_pkg::*;

  logic                  long_mode_q;
  logic                  in_vld_q, in_vld_d, out_vld_q, out_vld_d;
  logic [99:0]           in_q;
  logic [OUT_TDATA_W-1:0] out_q, out_d;
  logic                  hit_q;
  logic                  adv_out, take_in;
  dec_t                  dec;

  assign adv_out = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || adv_out;
  assign take_in = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    in_vld_d  = s_axis_tready_o ? s_axis_tvalid_i : in_vld_q;
    out_vld_d = adv_out ? in_vld_q : out_vld_q;
  end

  x86d_decode #(
    .WINDOW_BYTES (WINDOW_BYTES)
  ) u_decode (
    .long_mode_i  (long_mode_q),
    .bytes_low_i  (in_q[63:0]),
    .bytes_high_i (in_q[95:64]),
    .byte_count_i (in_q[99:96]),
    .dec_o        (dec)
  );

  always_comb begin
    out_d = {3'd0, dec.flow, dec.fund, dec.ftst, dec.fmod, dec.used,
             dec.dsz, dec.scale, dec.base, dec.disp, dec.imm, dec.opnd1,
             dec.opnd0, dec.attr, 5'(dec.op), dec.len};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b1;
      in_vld_q    <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) long_mode_q <= cfg_wdata_i;
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) in_q <= s_axis_tdata_i[99:0];
    if (adv_out && in_vld_q) begin
      out_q <= out_d;
      hit_q <= dec.hit;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_q;
  assign m_axis_tuser_o  = hit_q;

endmodule
